>>> design/selsamp_pkg.sv
package selsamp_pkg;

	// Configuration register map
	localparam int unsigned CFG_ADDR_BITS = 1;
	localparam logic [CFG_ADDR_BITS-1:0] REG_POPULATION = 1'd0;
	localparam logic [CFG_ADDR_BITS-1:0] REG_SAMPLE     = 1'd1;

	// Remainder unit handshake
	typedef struct packed {
		logic start;
	} rem_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} rem_rsp_t;

endpackage

>>> design/selsamp_if.sv
// Input stream: one random word per transaction
interface selsamp_in_if #(
	parameter int unsigned RANDOM_BITS = 31
);
	logic                   valid;
	logic                   ready;
	logic [RANDOM_BITS-1:0] random_word;

	modport source (output valid, output random_word, input ready);
	modport sink   (input valid, input random_word, output ready);
endinterface

// Output stream: one examined candidate per transaction
interface selsamp_out_if #(
	parameter int unsigned INDEX_BITS = 16
);
	logic                  valid;
	logic                  ready;
	logic [INDEX_BITS-1:0] index;
	logic                  chosen;
	logic                  last;

	modport source (output valid, output index, output chosen, output last, input ready);
	modport sink   (input valid, input index, input chosen, input last, output ready);
endinterface

// Configuration write channel
interface selsamp_cfg_if import selsamp_pkg::*; #(
	parameter int unsigned INDEX_BITS = 16
);
	logic                     valid;
	logic                     ready;
	logic [CFG_ADDR_BITS-1:0] addr;
	logic [INDEX_BITS-1:0]    data;

	modport source (output valid, output addr, output data, input ready);
	modport sink   (input valid, input addr, input data, output ready);
endinterface

>>> design/selsamp_rem.sv
module selsamp_rem import selsamp_pkg::*; #(
	parameter int unsigned DVD_BITS = 31,
	parameter int unsigned DIV_BITS = 17
) (
	input  logic                clk,
	input  logic                arst_n,
	input  rem_req_t            req,
	input  logic [DVD_BITS-1:0] dividend,
	input  logic [DIV_BITS-1:0] divisor,
	output rem_rsp_t            rsp,
	output logic [DIV_BITS-1:0] remainder
);

	localparam int unsigned CNT_BITS = $clog2(DVD_BITS + 1);

	logic [DVD_BITS-1:0] dvd_q;
	logic [DIV_BITS-1:0] dsr_q;
	logic [DIV_BITS-1:0] rem_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic                busy_q;
	logic                done_q;

	logic [DIV_BITS:0]   trial;
	logic [DIV_BITS:0]   diff;
	logic [DIV_BITS-1:0] rem_next;

	// Restoring step: bring down one dividend bit, subtract if it fits
	always_comb begin
		trial    = {rem_q, dvd_q[DVD_BITS-1]};
		diff     = trial - {1'b0, dsr_q};
		rem_next = (trial >= {1'b0, dsr_q}) ? diff[DIV_BITS-1:0] : trial[DIV_BITS-1:0];
	end

	// Sequence one bit per cycle, most significant first
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_BITS'(DVD_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_BITS'(1);
				if (cnt_q == CNT_BITS'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Operand and partial remainder registers
	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DVD_BITS-2:0], 1'b0};
			rem_q <= rem_next;
		end
	end

	assign rsp.busy  = busy_q;
	assign rsp.done  = done_q;
	assign remainder = rem_q;

endmodule

>>> design/selection_sampling.sv
// Selection sampling: each run walks a candidate index from population_size-1 down to 0,
// one index per input transaction, and marks it chosen when random_word mod (index+1)
// is below the count still needed, so exactly min(sample_size, population_size) indices
// come out chosen, in descending order; the result for index 0 carries last, and the next
// input starts a fresh run from the configuration registers (a population of zero counts
// as one). Each item passes through these steps in order: accepting the input loads the
// random word and divisor into one shared restoring remainder unit, the unit retires the
// random bits one at a time, most significant first, and reports completion, and the
// result is then loaded into the output register, after which the next input is accepted.
// The input is accepted again while a result still waits on the output; the next result
// then holds in the sequencer until the output register frees up. Configuration writes
// are always accepted and should land between runs or while the block is idle.
module selection_sampling import selsamp_pkg::*; #(
	parameter int unsigned INDEX_BITS  = 16,
	parameter int unsigned RANDOM_BITS = 31
) (
	input logic               clk,
	input logic               arst_n,
	selsamp_in_if.sink        word_ch,
	selsamp_out_if.source     result_ch,
	selsamp_cfg_if.sink       cfg
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	logic [1:0]            state_q;
	logic [INDEX_BITS-1:0] pop_q;
	logic [INDEX_BITS-1:0] sample_q;
	logic [INDEX_BITS-1:0] cur_q;
	logic [INDEX_BITS-1:0] need_q;
	logic                  run_active_q;

	logic                  out_valid_q;
	logic [INDEX_BITS-1:0] out_index_q;
	logic                  out_chosen_q;
	logic                  out_last_q;

	logic                  in_accept;
	logic                  slot_free;
	logic                  emit;
	logic [INDEX_BITS-1:0] pop_eff;
	logic [INDEX_BITS-1:0] start_index;
	logic [INDEX_BITS-1:0] start_need;
	logic [INDEX_BITS-1:0] cur_now;
	logic [INDEX_BITS:0]   divisor;
	logic                  pick;
	logic                  at_zero;

	rem_req_t              rem_req;
	rem_rsp_t              rem_rsp;
	logic [INDEX_BITS:0]   remainder;

	// Handshakes
	assign word_ch.ready = (state_q == ST_IDLE);
	assign in_accept     = word_ch.valid && word_ch.ready;
	assign cfg.ready     = 1'b1;
	assign slot_free     = !out_valid_q || result_ch.ready;
	assign emit          = (state_q == ST_EMIT) && slot_free;

	// Run start values from configuration
	always_comb begin
		pop_eff     = (pop_q == '0) ? INDEX_BITS'(1) : pop_q;
		start_index = pop_eff - INDEX_BITS'(1);
		start_need  = (sample_q > pop_eff) ? pop_eff : sample_q;
		cur_now     = run_active_q ? cur_q : start_index;
		divisor     = {1'b0, cur_now} + (INDEX_BITS + 1)'(1);
	end

	// Decision for the current index
	assign pick    = remainder[INDEX_BITS-1:0] < need_q;
	assign at_zero = (cur_q == '0);

	assign rem_req.start = in_accept;

	selsamp_rem #(
		.DVD_BITS (RANDOM_BITS),
		.DIV_BITS (INDEX_BITS + 1)
	) u_rem (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (rem_req),
		.dividend  (word_ch.random_word),
		.divisor   (divisor),
		.rsp       (rem_rsp),
		.remainder (remainder)
	);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop_q    <= INDEX_BITS'(1);
			sample_q <= '0;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.addr)
				REG_POPULATION: pop_q    <= cfg.data;
				REG_SAMPLE:     sample_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: if (in_accept) state_q <= ST_DIV;
				ST_DIV:  if (rem_rsp.done) state_q <= ST_EMIT;
				ST_EMIT: if (slot_free) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Run state: load at run start, advance on each emitted result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_active_q <= 1'b0;
			cur_q        <= '0;
			need_q       <= '0;
		end else if (in_accept && !run_active_q) begin
			run_active_q <= 1'b1;
			cur_q        <= start_index;
			need_q       <= start_need;
		end else if (emit) begin
			need_q <= need_q - INDEX_BITS'(pick);
			if (at_zero) begin
				run_active_q <= 1'b0;
			end else begin
				cur_q <= cur_q - INDEX_BITS'(1);
			end
		end
	end

	// Output register: hold until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (result_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_index_q  <= cur_q;
			out_chosen_q <= pick;
			out_last_q   <= at_zero;
		end
	end

	assign result_ch.valid  = out_valid_q;
	assign result_ch.index  = out_index_q;
	assign result_ch.chosen = out_chosen_q;
	assign result_ch.last   = out_last_q;

endmodule

>>> design/selsamp_checker.sv
module selsamp_assert #(
	parameter int unsigned INDEX_BITS  = 16,
	parameter int unsigned RANDOM_BITS = 31
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_ready,
	input logic                  out_valid,
	input logic                  out_ready,
	input logic [INDEX_BITS-1:0] out_index,
	input logic                  out_chosen,
	input logic                  out_last
);

	// A stalled result stays offered
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// A stalled result keeps its payload
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=>
			$stable(out_index) && $stable(out_chosen) && $stable(out_last))
		else $error("result changed while stalled");

	// Last marks exactly the result for index zero
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_last == (out_index == '0)))
		else $error("last flag does not match index zero");

	// The block stays busy for the whole remainder computation
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> (!in_ready) [*RANDOM_BITS+2])
		else $error("input taken during a running decision");

endmodule

bind selection_sampling selsamp_assert #(
	.INDEX_BITS  (INDEX_BITS),
	.RANDOM_BITS (RANDOM_BITS)
) u_selsamp_assert (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (word_ch.valid),
	.in_ready   (word_ch.ready),
	.out_valid  (result_ch.valid),
	.out_ready  (result_ch.ready),
	.out_index  (result_ch.index),
	.out_chosen (result_ch.chosen),
	.out_last   (result_ch.last)
);

>>> verif/selsamp_checker.sv
module selsamp_checker import selsamp_pkg::*; #(
	parameter int unsigned INDEX_BITS  = 16,
	parameter int unsigned RANDOM_BITS = 31
) (
	input  logic   clk,
	input  logic   arst_n,
	selsamp_in_if  in_ch,
	selsamp_out_if out_ch,
	selsamp_cfg_if cfg,
	output int     errors,
	output int     pending,
	output int     checked,
	output int     runs_closed,
	output int     picked
);

	typedef struct packed {
		logic [INDEX_BITS-1:0] index;
		logic                  chosen;
		logic                  last;
	} step_t;

	// expected steps, oldest first
	step_t steps_due[$];

	// register shadows and the state of the walk
	logic [INDEX_BITS-1:0] population_reg;
	logic [INDEX_BITS-1:0] sample_reg;
	logic [INDEX_BITS-1:0] walk_index;
	logic [INDEX_BITS-1:0] need_left;
	logic                  in_run;

	int error_count  = 0;
	int step_count   = 0;
	int run_count    = 0;
	int chosen_count = 0;

	assign errors      = error_count;
	assign pending     = steps_due.size();
	assign checked     = step_count;
	assign runs_closed = run_count;
	assign picked      = chosen_count;

	// examine one candidate; open a new walk from the registers when none is active
	function automatic step_t examine(input logic [RANDOM_BITS-1:0] word);
		step_t                 s;
		logic [INDEX_BITS-1:0] n;
		longint unsigned       rem;
		if (!in_run) begin
			n          = (population_reg == '0) ? INDEX_BITS'(1) : population_reg;
			walk_index = n - INDEX_BITS'(1);
			need_left  = (sample_reg > n) ? n : sample_reg;
			in_run     = 1'b1;
		end
		rem      = 64'(word) % (64'(walk_index) + 64'd1);
		s.index  = walk_index;
		s.chosen = (rem < 64'(need_left));
		s.last   = (walk_index == '0);
		if (s.chosen)
			need_left = need_left - INDEX_BITS'(1);
		if (s.last)
			in_run = 1'b0;
		else
			walk_index = walk_index - INDEX_BITS'(1);
		return s;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		step_t got;
		step_t want;
		logic  bad;
		if (!arst_n) begin
			population_reg = INDEX_BITS'(1);
			sample_reg     = '0;
			walk_index     = '0;
			need_left      = '0;
			in_run         = 1'b0;
			steps_due.delete();
		end else begin
			// track register writes
			if (cfg.valid && cfg.ready) begin
				case (cfg.addr)
					REG_POPULATION: population_reg = cfg.data;
					REG_SAMPLE:     sample_reg     = cfg.data;
					default: ;
				endcase
			end

			// predict on each accepted input transaction
			if (in_ch.valid && in_ch.ready)
				steps_due.insert(steps_due.size(), examine(in_ch.random_word));

			// compare each accepted output transaction with the oldest prediction
			if (out_ch.valid && out_ch.ready) begin
				got.index  = out_ch.index;
				got.chosen = out_ch.chosen;
				got.last   = out_ch.last;
				step_count++;
				if (got.last)
					run_count++;
				if (got.chosen)
					chosen_count++;
				if (steps_due.size() == 0) begin
					error_count++;
					$display("%0t: unexpected result index %0d chosen %b last %b, expected none",
						$time, got.index, got.chosen, got.last);
				end else begin
					want = steps_due.pop_front();
					bad  = 1'b0;
					if (got.index !== want.index) begin
						bad = 1'b1;
						$display("%0t: index expected %0d, actual %0d",
							$time, want.index, got.index);
					end
					if (got.chosen !== want.chosen) begin
						bad = 1'b1;
						$display("%0t: chosen for index %0d expected %b, actual %b",
							$time, want.index, want.chosen, got.chosen);
					end
					if (got.last !== want.last) begin
						bad = 1'b1;
						$display("%0t: last for index %0d expected %b, actual %b",
							$time, want.index, want.last, got.last);
					end
					if (bad)
						error_count++;
				end
			end
		end
	end

endmodule

>>> verif/tb.sv
module tb;
	import selsamp_pkg::*;

	localparam int unsigned INDEX_BITS   = 16;
	localparam int unsigned RANDOM_BITS  = 31;
	localparam int          RANDOM_ITEMS = 1250;
	localparam int          HOLD_AT      = 12000;
	localparam int          HOLD_CYCLES  = 600;
	localparam int          TAIL_CYCLES  = 40;
	localparam logic [RANDOM_BITS-1:0] WORD_MAX = '1;
	localparam logic [INDEX_BITS-1:0]  SIZE_MAX = '1;

	logic clk = 1'b0;
	logic arst_n;

	always #5 clk = ~clk;

	selsamp_in_if  #(.RANDOM_BITS(RANDOM_BITS)) in_ch  ();
	selsamp_out_if #(.INDEX_BITS(INDEX_BITS))   out_ch ();
	selsamp_cfg_if #(.INDEX_BITS(INDEX_BITS))   cfg    ();

	int errors;
	int pending;
	int checked;
	int runs_closed;
	int picked;

	selection_sampling #(
		.INDEX_BITS (INDEX_BITS),
		.RANDOM_BITS(RANDOM_BITS)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.word_ch  (in_ch),
		.result_ch(out_ch),
		.cfg      (cfg)
	);

	selsamp_checker #(
		.INDEX_BITS (INDEX_BITS),
		.RANDOM_BITS(RANDOM_BITS)
	) u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_ch      (in_ch),
		.out_ch     (out_ch),
		.cfg        (cfg),
		.errors     (errors),
		.pending    (pending),
		.checked    (checked),
		.runs_closed(runs_closed),
		.picked     (picked)
	);

	// sender bookkeeping: words sent, burst position, candidates left in the open walk
	int words_sent = 0;
	int burst_left = 0;
	int run_left   = 0;
	int run_length = 1;

	task automatic send_word(input logic [RANDOM_BITS-1:0] word);
		if (run_left == 0)
			run_left = run_length;
		run_left--;
		in_ch.valid       <= 1'b1;
		in_ch.random_word <= word;
		do @(posedge clk); while (in_ch.ready !== 1'b1);
		words_sent++;
	endtask

	// send a number of words in bursts with random gaps
	task automatic feed(input int count, input bit extremes);
		logic [RANDOM_BITS-1:0] word;
		int                     gap;
		for (int k = 0; k < count; k++) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 24);
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
				if (gap != 0) begin
					in_ch.valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			burst_left--;
			if (extremes)
				word = k[0] ? WORD_MAX : '0;
			else begin
				case ($urandom_range(0, 7))
					0:       word = RANDOM_BITS'($urandom_range(0, 15));
					1:       word = WORD_MAX - RANDOM_BITS'($urandom_range(0, 15));
					default: word = RANDOM_BITS'($urandom);
				endcase
			end
			send_word(word);
		end
		in_ch.valid <= 1'b0;
	endtask

	// write both size registers back to back
	task automatic set_sizes(input logic [INDEX_BITS-1:0] pop, input logic [INDEX_BITS-1:0] samp);
		cfg.valid <= 1'b1;
		cfg.addr  <= REG_POPULATION;
		cfg.data  <= pop;
		do @(posedge clk); while (cfg.ready !== 1'b1);
		cfg.addr <= REG_SAMPLE;
		cfg.data <= samp;
		do @(posedge clk); while (cfg.ready !== 1'b1);
		cfg.valid  <= 1'b0;
		run_length = (pop == '0) ? 1 : int'(pop);
	endtask

	// hold until every predicted result has come back
	task automatic wait_idle();
		do @(negedge clk); while (pending != 0);
		@(posedge clk);
	endtask

	// receiver: stretches of different stall density, one long hold-off
	initial begin : receiver
		int cycle_no;
		int stretch;
		int stall_pct;
		bit held;
		out_ch.ready <= 1'b0;
		cycle_no = 0;
		held     = 1'b0;
		@(posedge arst_n);
		forever begin
			stretch = $urandom_range(1, 80);
			case ($urandom_range(0, 3))
				0:       stall_pct = 0;
				1:       stall_pct = 20;
				2:       stall_pct = 50;
				default: stall_pct = 85;
			endcase
			repeat (stretch) begin
				@(posedge clk);
				cycle_no++;
				if (!held && cycle_no >= HOLD_AT) begin
					held = 1'b1;
					out_ch.ready <= 1'b0;
					repeat (HOLD_CYCLES) @(posedge clk);
					cycle_no += HOLD_CYCLES;
				end
				out_ch.ready <= (int'($urandom_range(0, 99)) >= stall_pct);
			end
		end
	end

	// stimulus and verdict
	initial begin : stimulus
		int                    target;
		int                    count;
		int                    eff;
		logic [INDEX_BITS-1:0] pop;
		logic [INDEX_BITS-1:0] samp;
		arst_n            <= 1'b0;
		in_ch.valid       <= 1'b0;
		in_ch.random_word <= '0;
		cfg.valid         <= 1'b0;
		cfg.addr          <= REG_POPULATION;
		cfg.data          <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset sizes: lone index 0, never chosen
		feed(2, 1'b1);
		// zero population acts as one, oversized sample is clamped
		wait_idle();
		set_sizes('0, SIZE_MAX);
		feed(2, 1'b1);
		wait_idle();
		set_sizes(INDEX_BITS'(4), INDEX_BITS'(2));
		feed(4, 1'b1);
		// change sizes in the middle of a walk, then a walk with nothing needed
		wait_idle();
		set_sizes(INDEX_BITS'(6), INDEX_BITS'(3));
		feed(2, 1'b1);
		wait_idle();
		set_sizes(INDEX_BITS'(3), '0);
		feed(7, 1'b1);
		// sample equal to population: every index chosen
		wait_idle();
		set_sizes(INDEX_BITS'(5), INDEX_BITS'(5));
		feed(5, 1'b0);

		// random phases: mostly whole walks, some cut short
		target = words_sent + RANDOM_ITEMS;
		while (words_sent < target) begin
			case ($urandom_range(0, 19))
				0:            pop = '0;
				1:            pop = INDEX_BITS'(1);
				17, 18, 19:   pop = INDEX_BITS'($urandom_range(41, 200));
				default:      pop = INDEX_BITS'($urandom_range(2, 40));
			endcase
			eff = (pop == '0) ? 1 : int'(pop);
			case ($urandom_range(0, 9))
				0:       samp = '0;
				1:       samp = SIZE_MAX;
				2:       samp = INDEX_BITS'(eff);
				3:       samp = INDEX_BITS'(eff + int'($urandom_range(1, 5)));
				default: samp = INDEX_BITS'($urandom_range(0, eff));
			endcase
			if ($urandom_range(0, 9) < 7)
				count = run_left + eff * int'($urandom_range(1, (eff > 40) ? 1 : 3));
			else
				count = int'($urandom_range(1, 2 * eff));
			wait_idle();
			set_sizes(pop, samp);
			feed(count, 1'b0);
		end

		// close the open walk, then start the widest one and take its top indices
		wait_idle();
		set_sizes(SIZE_MAX, INDEX_BITS'(16'h8000));
		feed(run_left + 20, 1'b0);

		// drain
		do @(negedge clk); while (pending != 0);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Sent %0d random words; checked %0d results over %0d completed walks, %0d chosen.",
			words_sent, checked, runs_closed, picked);
		$display("Populations from zero up to %0d, samples from empty to clamped,",
			SIZE_MAX);
		$display("sizes changed mid-walk, long output stall.");
		if (errors == 0 && pending == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// watchdog
	initial begin
		#6000000;
		$display("Verification failed");
		$finish;
	end

endmodule
